>>> hdl/fed_pkg.sv
// Package for the feedback echo delay block.
// Holds the sample and pointer widths, the register indexes and the stage struct.
// No dependencies; every other file of the block imports it.
package fed_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int ADDR_BITS   = 16;
  localparam int DEPTH       = 1 << ADDR_BITS;
  localparam int DELAY_BITS  = 16;
  localparam int DECAY_BITS  = 17;
  localparam int POS_BITS    = 17;
  localparam int CFG_BITS    = 17;

  // Position saturates at its largest value; one in Q1.16 is 65536.
  localparam logic [POS_BITS-1:0]   POS_MAX = {POS_BITS{1'b1}};
  localparam logic [DECAY_BITS-1:0] ONE_Q16 = DECAY_BITS'(1 << 16);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_DELAY_SAMPLES = 1'b0,
    REG_DECAY_Q16     = 1'b1
  } cfg_reg_e;

  // One sample in the mix stage: the input value and whether the echo may apply.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          echo;
  } mix_stage_t;

endpackage

>>> hdl/fed_delay_mem.sv
// Delay memory of past output samples for the feedback echo delay block.
// One write port and one read port with registered read data; uses fed_pkg.
module fed_delay_mem (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [fed_pkg::ADDR_BITS-1:0]          waddr_i,
  input  logic signed [fed_pkg::SAMPLE_BITS-1:0] wdata_i,
  input  logic                                   re_i,
  input  logic [fed_pkg::ADDR_BITS-1:0]          raddr_i,
  output logic signed [fed_pkg::SAMPLE_BITS-1:0] rdata_o
);
  import fed_pkg::*;

  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; a read at an address being written returns the old entry.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/fed_mix.sv
// Echo mix of the feedback echo delay block: blends a sample with the delayed
// output, floors and saturates. Combinational; uses fed_pkg.
module fed_mix (
  input  fed_pkg::mix_stage_t                    stage_i,
  input  logic signed [fed_pkg::SAMPLE_BITS-1:0] delayed_i,
  input  logic [fed_pkg::DECAY_BITS-1:0]         decay_i,
  output logic signed [fed_pkg::SAMPLE_BITS-1:0] sample_o
);
  import fed_pkg::*;

  localparam int DIFF_BITS = SAMPLE_BITS + 1;
  localparam int PROD_BITS = DIFF_BITS + DECAY_BITS + 1;
  localparam int TERM_BITS = PROD_BITS - 16;
  localparam int SUM_BITS  = TERM_BITS + 1;

  logic signed [DIFF_BITS-1:0]   diff;
  logic signed [DECAY_BITS:0]    decay_s;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [TERM_BITS-1:0]   term;
  logic signed [SUM_BITS-1:0]    sum;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic                          in_range;

  // (1-a)*x + a*d equals x + a*(d-x); the x term is a whole multiple of one,
  // so flooring the product alone floors the full sum.
  always_comb begin
    diff    = {delayed_i[SAMPLE_BITS-1], delayed_i}
            - {stage_i.sample[SAMPLE_BITS-1], stage_i.sample};
    decay_s = {1'b0, decay_i};
    prod    = decay_s * diff;
    term    = prod[PROD_BITS-1:16];
    sum     = {{(SUM_BITS-SAMPLE_BITS){stage_i.sample[SAMPLE_BITS-1]}}, stage_i.sample}
            + {term[TERM_BITS-1], term};
  end

  // Saturate to the sample width.
  always_comb begin
    in_range = (sum[SUM_BITS-1:SAMPLE_BITS-1] == '0)
            || (sum[SUM_BITS-1:SAMPLE_BITS-1] == '1);
    if (in_range) begin
      sat = sum[SAMPLE_BITS-1:0];
    end else if (sum[SUM_BITS-1]) begin
      sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // A zero delayed output leaves the sample unchanged.
  assign sample_o = (stage_i.echo && (delayed_i != '0)) ? sat : stage_i.sample;

endmodule

>>> hdl/feedback_echo_delay.sv
// Top level of the feedback echo delay block.
// Holds the pointers, the configuration and the pipeline registers;
// uses fed_pkg, fed_delay_mem and fed_mix.
//
// Feedback echo on signed 24-bit samples: one sample per clock cycle is
// accepted unless the output side stalls; each yields one result via the mix
// stage and output registers. The delay memory (65536 x 24 bits, one write
// and one registered read port) is read when a sample is taken and written
// when its result moves to the output register; a delay of one reads the
// result still in the mix stage through a forwarding path. The memory has no
// reset: entries are only used once the position count shows they were
// written. start_req_i set restarts the position count at this sample.
// Configuration writes are taken at any time but are meant for idle periods.
module feedback_echo_delay (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [0:0]                             cfg_index_i,
  input  logic [fed_pkg::CFG_BITS-1:0]           cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [fed_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic                                   start_req_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [fed_pkg::SAMPLE_BITS-1:0] sample_out_o
);
  import fed_pkg::*;

  logic [DELAY_BITS-1:0]         delay_q;
  logic [DECAY_BITS-1:0]         decay_q;
  logic [DECAY_BITS-1:0]         decay_sat;
  logic [ADDR_BITS-1:0]          wp_q;
  logic [POS_BITS-1:0]           pos_q;
  logic [POS_BITS-1:0]           pos;
  logic [ADDR_BITS-1:0]          rd_addr;

  logic                          s1_valid_q;
  mix_stage_t                    s1_q;
  mix_stage_t                    s1_d;
  logic [ADDR_BITS-1:0]          s1_wp_q;
  logic                          s1_fwd_q;
  logic signed [SAMPLE_BITS-1:0] s1_fwd_data_q;
  logic                          s1_advance;
  logic                          s1_move;
  logic                          fwd;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;

  logic                          in_fire;
  logic signed [SAMPLE_BITS-1:0] mem_rdata;
  logic signed [SAMPLE_BITS-1:0] delayed;
  logic signed [SAMPLE_BITS-1:0] mix_y;

  // Handshake: the mix stage moves on when the output register is free or
  // its result is taken in the same cycle.
  assign s1_advance = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && s1_advance;
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_BITS'(1);
      decay_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_DELAY_SAMPLES: delay_q <= cfg_data_i[DELAY_BITS-1:0];
        REG_DECAY_Q16:     decay_q <= cfg_data_i[DECAY_BITS-1:0];
        default:           ;
      endcase
    end
  end

  assign decay_sat = (decay_q > ONE_Q16) ? ONE_Q16 : decay_q;

  // Position of the incoming sample and the entry written delay samples ago.
  always_comb begin
    pos     = start_req_i ? '0 : pos_q;
    rd_addr = wp_q - delay_q;
    fwd     = s1_valid_q && (s1_wp_q == rd_addr);
    s1_d.sample = sample_in_i;
    s1_d.echo   = (pos > POS_BITS'(delay_q));
  end

  // Write pointer and position count advance with each transfer in.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      pos_q <= '0;
    end else if (in_fire) begin
      wp_q  <= wp_q + ADDR_BITS'(1);
      pos_q <= (pos < POS_MAX) ? pos + POS_BITS'(1) : POS_MAX;
    end
  end

  // Mix stage valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Mix stage payload; the forwarded value is the result leaving the stage now.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q          <= s1_d;
      s1_wp_q       <= wp_q;
      s1_fwd_q      <= fwd;
      s1_fwd_data_q <= mix_y;
    end
  end

  fed_delay_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (s1_move),
    .waddr_i (s1_wp_q),
    .wdata_i (mix_y),
    .re_i    (in_fire),
    .raddr_i (rd_addr),
    .rdata_o (mem_rdata)
  );

  assign delayed = s1_fwd_q ? s1_fwd_data_q : mem_rdata;

  fed_mix u_mix (
    .stage_i   (s1_q),
    .delayed_i (delayed),
    .decay_i   (decay_sat),
    .sample_o  (mix_y)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_sample_q <= mix_y;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;

endmodule

>>> tb/feedback_echo_delay_tb.sv
// Self-checking testbench for the feedback echo delay block.
// Drives samples and register writes, predicts every echoed sample and checks each transfer.
// Depends on fed_pkg and feedback_echo_delay.
module feedback_echo_delay_tb;
  import fed_pkg::*;

  localparam int  HOLD_CYCLES  = 300;
  localparam int  DRAIN_CYCLES = 8;
  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  typedef enum bit {ROW_SAMPLE, ROW_CONFIG} row_kind_e;
  typedef enum {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_e;

  // One row of the directed table: either a register pair or a sample.
  typedef struct packed {
    row_kind_e                     kind;
    logic [DELAY_BITS-1:0]         dly;
    logic [DECAY_BITS-1:0]         dec;
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          st;
    logic                          typed;
    logic signed [SAMPLE_BITS-1:0] want;
  } dir_row_t;

  localparam int N_DIRECTED = 23;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // Reset settings: delay one, no decay, so every sample passes.
    '{ROW_SAMPLE, 16'd0, 17'd0,  24'sd8388607, 1'b1, 1'b1,  24'sd8388607},
    '{ROW_SAMPLE, 16'd0, 17'd0, -24'sd8388608, 1'b0, 1'b1, -24'sd8388608},
    '{ROW_SAMPLE, 16'd0, 17'd0,  24'sd0,       1'b0, 1'b1,  24'sd0},
    '{ROW_SAMPLE, 16'd0, 17'd0, -24'sd1,       1'b0, 1'b1, -24'sd1},
    '{ROW_SAMPLE, 16'd0, 17'd0,  24'sd1,       1'b0, 1'b1,  24'sd1},
    // Decay of one: the delayed output replaces the sample.
    '{ROW_CONFIG, 16'd1, 17'd65536, 24'sd0,    1'b0, 1'b0,  24'sd0},
    '{ROW_SAMPLE, 16'd0, 17'd0,  24'sd100,     1'b1, 1'b1,  24'sd100},
    '{ROW_SAMPLE, 16'd0, 17'd0,  24'sd5,       1'b0, 1'b1,  24'sd5},
    '{ROW_SAMPLE, 16'd0, 17'd0,  24'sd7,       1'b0, 1'b1,  24'sd5},
    '{ROW_SAMPLE, 16'd0, 17'd0,  24'sd9,       1'b0, 1'b1,  24'sd5},
    // Decay above one is clamped to one.
    '{ROW_CONFIG, 16'd1, 17'd131071, 24'sd0,   1'b0, 1'b0,  24'sd0},
    '{ROW_SAMPLE, 16'd0, 17'd0,  24'sd11,      1'b0, 1'b1,  24'sd5},
    // Half decay over two samples: full-scale mix and floor of negatives.
    '{ROW_CONFIG, 16'd2, 17'd32768, 24'sd0,    1'b0, 1'b0,  24'sd0},
    '{ROW_SAMPLE, 16'd0, 17'd0,  24'sd8388607, 1'b1, 1'b1,  24'sd8388607},
    '{ROW_SAMPLE, 16'd0, 17'd0,  24'sd8388607, 1'b0, 1'b1,  24'sd8388607},
    '{ROW_SAMPLE, 16'd0, 17'd0, -24'sd8388608, 1'b0, 1'b1, -24'sd8388608},
    '{ROW_SAMPLE, 16'd0, 17'd0,  24'sd8388607, 1'b0, 1'b1,  24'sd8388607},
    '{ROW_SAMPLE, 16'd0, 17'd0, -24'sd3,       1'b0, 1'b0,  24'sd0},
    '{ROW_SAMPLE, 16'd0, 17'd0, -24'sd8388608, 1'b0, 1'b0,  24'sd0},
    // A start restarts the position; a zero delayed output passes the sample.
    '{ROW_SAMPLE, 16'd0, 17'd0,  24'sd8388607, 1'b1, 1'b1,  24'sd8388607},
    '{ROW_SAMPLE, 16'd0, 17'd0,  24'sd0,       1'b0, 1'b1,  24'sd0},
    '{ROW_SAMPLE, 16'd0, 17'd0,  24'sd1,       1'b0, 1'b1,  24'sd1},
    '{ROW_SAMPLE, 16'd0, 17'd0, -24'sd8388608, 1'b0, 1'b1, -24'sd8388608}
  };

  logic                          clk_i       = 1'b0;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [0:0]                    cfg_index_i = REG_DELAY_SAMPLES;
  logic [CFG_BITS-1:0]           cfg_data_i  = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic signed [SAMPLE_BITS-1:0] sample_in_i = '0;
  logic                          start_req_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_out_o;

  // Predicted state of the echo: past outputs, pointer, position and settings.
  logic signed [SAMPLE_BITS-1:0] echo_mem [DEPTH];
  logic [ADDR_BITS-1:0]          wr_ptr_m  = '0;
  logic [POS_BITS-1:0]           pos_m     = '0;
  logic [DELAY_BITS-1:0]         delay_m   = DELAY_BITS'(1);
  logic [DECAY_BITS-1:0]         decay_m   = '0;

  logic signed [SAMPLE_BITS-1:0] expected_samples [$];
  gap_mode_e gap_mode      = GAP_NONE;
  int        hold_requests = 0;
  int        error_count   = 0;
  int        sample_count  = 0;
  int        result_count  = 0;

  feedback_echo_delay dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .start_req_i  (start_req_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

  // Clock with a period of ten.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the predicted echo by one sample and return its output.
  function automatic logic signed [SAMPLE_BITS-1:0] predict_echo(
    input logic signed [SAMPLE_BITS-1:0] x,
    input logic                          st
  );
    logic [DECAY_BITS-1:0]         dec;
    logic [POS_BITS-1:0]           pos;
    logic [ADDR_BITS-1:0]          rd;
    logic signed [SAMPLE_BITS-1:0] d;
    logic signed [SAMPLE_BITS-1:0] y;
    longint                        acc;
    dec = (decay_m > ONE_Q16) ? ONE_Q16 : decay_m;
    pos = st ? '0 : pos_m;
    y   = x;
    if (pos > POS_BITS'(delay_m)) begin
      rd = wr_ptr_m - delay_m;
      d  = echo_mem[rd];
      if (d != 0) begin
        acc = longint'(ONE_Q16 - dec) * longint'(x) + longint'(dec) * longint'(d);
        acc = acc >>> 16;
        if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
        if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
        y = SAMPLE_BITS'(acc);
      end
    end
    echo_mem[wr_ptr_m] = y;
    wr_ptr_m = wr_ptr_m + 1'b1;
    pos_m    = (pos < POS_MAX) ? pos + 1'b1 : POS_MAX;
    return y;
  endfunction

  function automatic int send_gap_pct();
    return (gap_mode == GAP_SEND) ? 79 : (gap_mode == GAP_BOTH) ? 33 : 0;
  endfunction

  function automatic int recv_stall_pct();
    return (gap_mode == GAP_RECV) ? 79 : (gap_mode == GAP_BOTH) ? 33 : 0;
  endfunction

  // Random sample, weighted toward zero, the rails and small values.
  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return SAMPLE_BITS'(SAMPLE_MAX);
      2:       return SAMPLE_BITS'(SAMPLE_MIN);
      3:       return SAMPLE_BITS'(int'($urandom_range(0, 510)) - 255);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Offer one sample, wait for its transfer and record the expected output.
  task automatic send_sample(
    input logic signed [SAMPLE_BITS-1:0] s,
    input logic                          st,
    input logic                          typed,
    input logic signed [SAMPLE_BITS-1:0] want
  );
    logic signed [SAMPLE_BITS-1:0] got;
    while ($urandom_range(0, 99) < send_gap_pct()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    start_req_i <= st;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    got = predict_echo(s, st);
    expected_samples.push_back(typed ? want : got);
    sample_count++;
  endtask

  // Stop offering and let every outstanding result arrive.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write both registers while the block is idle.
  task automatic load_config(input logic [DELAY_BITS-1:0] dly, input logic [DECAY_BITS-1:0] dec);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_DELAY_SAMPLES;
    cfg_data_i  <= CFG_BITS'(dly);
    @(posedge clk_i);
    cfg_index_i <= REG_DECAY_Q16;
    cfg_data_i  <= CFG_BITS'(dec);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    delay_m  = dly;
    decay_m  = dec;
  endtask

  // Buffers of random length: mostly led by a start, with stray starts inside.
  task automatic run_buffers(input int count);
    int   left;
    int   len;
    int   k;
    logic st;
    left = count;
    while (left > 0) begin
      len = $urandom_range(1, int'(delay_m) + 40);
      for (k = 0; k < len && left > 0; k++) begin
        st = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
        send_sample(random_sample(), st, 1'b0, '0);
        left--;
      end
    end
  endtask

  function automatic logic [DELAY_BITS-1:0] random_delay();
    case ($urandom_range(0, 3))
      0:       return DELAY_BITS'(1);
      1:       return DELAY_BITS'(2);
      2:       return DELAY_BITS'($urandom_range(1, 8));
      default: return DELAY_BITS'($urandom_range(1, 40));
    endcase
  endfunction

  function automatic logic [DECAY_BITS-1:0] random_decay();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return ONE_Q16;
      2:       return DECAY_BITS'($urandom_range(65537, 131071));
      default: return DECAY_BITS'($urandom_range(0, 65536));
    endcase
  endfunction

  // Output side: check each transfer and drive ready, with stalls and hold-offs.
  initial begin : result_checker
    int hold_left;
    int hold_seen;
    logic signed [SAMPLE_BITS-1:0] want;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        result_count++;
        if (expected_samples.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %0d", $time, sample_out_o);
        end else begin
          want = expected_samples.pop_front();
          if (sample_out_o !== want) begin
            error_count++;
            $display("%0t: sample_out mismatch, expected %0d, actual %0d",
                     $time, want, sample_out_o);
          end
        end
      end
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct());
      end
    end
  end

  // Main sequence: directed rows, then random phases over every idle pattern.
  initial begin : stimulus
    int r;
    int phase;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < N_DIRECTED; r++) begin
      if (DIRECTED[r].kind == ROW_CONFIG)
        load_config(DIRECTED[r].dly, DIRECTED[r].dec);
      else
        send_sample(DIRECTED[r].smp, DIRECTED[r].st, DIRECTED[r].typed, DIRECTED[r].want);
    end

    // Random phases over every idle pattern; one starts with a long output hold-off.
    for (phase = 0; phase < 6; phase++) begin
      load_config(random_delay(), random_decay());
      case (phase)
        0, 4:    gap_mode = GAP_NONE;
        1:       gap_mode = GAP_SEND;
        2:       gap_mode = GAP_RECV;
        default: gap_mode = GAP_BOTH;
      endcase
      if (phase == 4) hold_requests++;
      run_buffers(100);
    end

    drain_results();
    $display("Sent %0d samples and checked %0d results: directed rows, then random buffers",
             sample_count, result_count);
    $display("with random settings under four idle patterns and one long output hold-off.");
    if (error_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog against a stalled handshake.
  initial begin : watchdog
    #10000000;
    $display("Timeout with %0d results outstanding.", expected_samples.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
